### rtl/cmsm_pkg.sv
// Shared types and constants for the column-wise median block.
`timescale 1ns / 1ps
package cmsm_pkg;

    localparam int VALUE_W    = 32;
    localparam int VLEN_IN_W  = 5;
    localparam int COL_OUT_W  = 4;
    localparam int CFG_W      = 9;
    localparam int BIT_IDX_W  = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [VALUE_W-1:0] MISSING_MARK = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] END_MARK     = 32'h8000_0001;
    // flips the sign bit so that signed order becomes unsigned order
    localparam logic [VALUE_W-1:0] SIGN_FLIP    = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_COUNT  = 4'b0010,
        ST_SELECT = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

endpackage

### rtl/cmsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cmsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/columnwise_median_skip_missing_core.sv
// Top level: matrix store and bit-serial median selection per column.
`timescale 1ns / 1ps
// Values are taken one per cycle while the block is idle and written into a
// single store of MAX_SAMPLES*MAX_COLUMNS words. On the item marked tlast with
// a nonzero vector length the block computes one median per column, column 0
// first, and takes no further item until the last column result has been taken.
// Each column costs one counting sweep over the ns samples plus 32 selection
// sweeps (one per bit of the value, most significant first) on the store's
// single read port; a column with no valid value skips the selection sweeps.
// The median is the element at position count/2 of the column's valid
// values in descending order; missing and end-of-vector marks are skipped.
module columnwise_median_skip_missing_core
    import cmsm_pkg::*;
#(
    parameter int MAX_SAMPLES = 256,
    parameter int MAX_COLUMNS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // value [31:0], vector_length [36:32], zero fill above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // column [3:0], median [35:4], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // empty_res
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int DEPTH = MAX_SAMPLES * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int VW    = $clog2(MAX_COLUMNS + 1);

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       sample_count_reg;
    logic [AW-1:0]          wpos_reg, wpos_next;
    logic [VW-1:0]          vlen_reg, vlen_next;
    logic [VW-1:0]          col_reg, col_next;
    logic [CW-1:0]          ns_reg, ns_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          raddr_reg, raddr_next;
    logic                   rvld_reg;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          k_reg, k_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [VALUE_W-1:0]     prefix_reg, prefix_next;
    logic [VALUE_W-1:0]     mask_reg, mask_next;
    logic [VALUE_W-1:0]     med_reg, med_next;
    logic                   empty_reg, empty_next;
    logic                   final_reg, final_next;

    logic                   in_acc, out_acc, issue, sweep_done;
    logic [VALUE_W-1:0]     rdata, key;
    logic                   elem_ok, elem_match;
    logic [VLEN_IN_W-1:0]   vlen_in;
    logic [VALUE_W-1:0]     prefix_set;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign vlen_in = s_axis_tdata[VALUE_W +: VLEN_IN_W];

    assign issue      = (state_reg == ST_COUNT || state_reg == ST_SELECT) && (idx_reg < ns_reg);
    assign sweep_done = (idx_reg == ns_reg) && !rvld_reg;

    cmsm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (in_acc),
        .waddr (wpos_reg),
        .wdata (s_axis_tdata[VALUE_W-1:0]),
        .re    (issue),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    assign key        = rdata ^ SIGN_FLIP;
    assign elem_ok    = rvld_reg && (rdata != MISSING_MARK) && (rdata != END_MARK);
    assign elem_match = ((key ^ prefix_reg) & mask_reg) == '0;
    assign prefix_set = prefix_reg | (VALUE_W'(1) << bit_reg);

    always_comb
    begin
        state_next  = state_reg;
        wpos_next   = wpos_reg;
        vlen_next   = vlen_reg;
        col_next    = col_reg;
        ns_next     = ns_reg;
        idx_next    = idx_reg;
        raddr_next  = raddr_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;
        mask_next   = mask_reg;
        med_next    = med_reg;
        empty_next  = empty_reg;
        final_next  = final_reg;

        if (issue)
        begin
            idx_next   = idx_reg + CW'(1);
            raddr_next = raddr_reg + AW'(vlen_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (int'(wpos_reg) == DEPTH - 1)
                        wpos_next = '0;
                    else
                        wpos_next = wpos_reg + AW'(1);
                    if (s_axis_tlast)
                    begin
                        wpos_next = '0;
                        if (int'(vlen_in) > MAX_COLUMNS)
                            vlen_next = VW'(MAX_COLUMNS);
                        else
                            vlen_next = VW'(vlen_in);
                        if (int'(sample_count_reg) > MAX_SAMPLES)
                            ns_next = CW'(MAX_SAMPLES);
                        else
                            ns_next = CW'(sample_count_reg);
                        col_next   = '0;
                        idx_next   = '0;
                        raddr_next = '0;
                        cnt_next   = '0;
                        if (vlen_in != '0)
                            state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT:
            begin
                if (elem_ok)
                    cnt_next = cnt_reg + CW'(1);
                if (sweep_done)
                begin
                    final_next = (col_reg + VW'(1)) == vlen_reg;
                    idx_next   = '0;
                    raddr_next = AW'(col_reg);
                    if (cnt_reg == '0)
                    begin
                        med_next   = MISSING_MARK;
                        empty_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        empty_next  = 1'b0;
                        k_next      = cnt_reg >> 1;
                        bit_next    = BIT_IDX_W'(VALUE_W - 1);
                        prefix_next = '0;
                        mask_next   = '0;
                        cnt_next    = '0;
                        state_next  = ST_SELECT;
                    end
                end
            end
            ST_SELECT:
            begin
                // cnt counts candidates with the current bit set
                if (elem_ok && elem_match && key[bit_reg])
                    cnt_next = cnt_reg + CW'(1);
                if (sweep_done)
                begin
                    if (cnt_reg > k_reg)
                        prefix_next = prefix_set;
                    else
                        k_next = k_reg - cnt_reg;
                    mask_next  = mask_reg | (VALUE_W'(1) << bit_reg);
                    cnt_next   = '0;
                    idx_next   = '0;
                    raddr_next = AW'(col_reg);
                    if (bit_reg == '0)
                    begin
                        med_next   = ((cnt_reg > k_reg) ? prefix_set : prefix_reg) ^ SIGN_FLIP;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        bit_next = bit_reg - BIT_IDX_W'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (final_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + VW'(1);
                        raddr_next = AW'(col_reg + VW'(1));
                        idx_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_COUNT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_count_reg <= CFG_W'(1);
            wpos_reg         <= '0;
            rvld_reg         <= 1'b0;
            idx_reg          <= '0;
            ns_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                sample_count_reg <= cfg_data;
            wpos_reg <= wpos_next;
            rvld_reg <= issue;
            idx_reg  <= idx_next;
            ns_reg   <= ns_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vlen_reg   <= vlen_next;
        col_reg    <= col_next;
        raddr_reg  <= raddr_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        mask_reg   <= mask_next;
        med_reg    <= med_next;
        empty_reg  <= empty_next;
        final_reg  <= final_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - COL_OUT_W){1'b0}}, med_reg,
                            COL_OUT_W'(col_reg)};
    assign m_axis_tuser  = empty_reg;
    assign m_axis_tlast  = final_reg;

    a_empty_is_missing: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (med_reg == MISSING_MARK))
        else $error("empty column without missing mark");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT || state_reg == ST_SELECT) |-> (idx_reg <= ns_reg))
        else $error("sweep ran past sample count");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SELECT) |-> (cnt_reg <= ns_reg))
        else $error("candidate count exceeds samples");

    a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> !rvld_reg || $past(issue))
        else $error("store read outside a sweep");

endmodule

### tb/sv/tb_columnwise_median_skip_missing_core.sv
// Testbench for the column-wise median block: directed table, then random records.
`timescale 1ns / 1ps
module tb_columnwise_median_skip_missing_core;
    import cmsm_pkg::*;

    localparam int NSAMP      = 256;
    localparam int NCOL       = 16;
    localparam int DEPTH      = NSAMP * NCOL;
    localparam int IDLE_LIMIT = 60000;
    localparam int HOLD_LEN   = 300;
    localparam int RAND_ITEMS = 420;

    typedef struct {
        logic [3:0]  column;
        logic [31:0] median;
        logic        empty;
        logic        fin;
    } median_t;

    typedef struct {
        logic [31:0] value;
        logic [4:0]  vlen;
        logic        last;
        bit          typed;
        logic [31:0] exp_median;
        logic        exp_empty;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_data;

    columnwise_median_skip_missing_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    // mirror of the block
    logic [31:0] store_copy [DEPTH];
    bit          store_written [DEPTH];
    logic [11:0] wr_pos;
    logic [8:0]  samples_cfg;

    median_t  pending_medians [$];
    dir_row_t dir_tab [$];

    int  err_count;
    int  items_sent;
    int  results_seen;
    int  records_sent;
    int  cyc;
    int  last_act;
    bit  hold_req;
    bit  hold_done;
    bit  quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h expected %h (result %0d)", what, got, want,
                 results_seen);
        err_count++;
    endtask

    function automatic void predict_medians(input logic [31:0] v, input logic [4:0] vl,
                                            input logic lst, input bit keep);
        int ns;
        int nv;
        int cnt;
        int k;
        logic [31:0] e;
        logic signed [31:0] x;
        logic signed [31:0] gath [NSAMP];
        median_t r;
        store_copy[wr_pos] = v;
        store_written[wr_pos] = 1'b1;
        wr_pos = wr_pos + 12'd1;
        if (!lst)
            return;
        wr_pos = '0;
        nv = (vl > NCOL) ? NCOL : vl;
        ns = (samples_cfg > NSAMP) ? NSAMP : samples_cfg;
        for (int c = 0; c < nv; c++)
        begin
            cnt = 0;
            for (int s = 0; s < ns; s++)
            begin
                e = store_copy[(s * nv + c) % DEPTH];
                if (e != MISSING_MARK && e != END_MARK)
                begin
                    x = e;
                    k = cnt;
                    while (k > 0 && gath[k-1] < x)
                    begin
                        gath[k] = gath[k-1];
                        k--;
                    end
                    gath[k] = x;
                    cnt++;
                end
            end
            r.column = c[3:0];
            r.median = (cnt > 0) ? gath[cnt/2] : MISSING_MARK;
            r.empty  = (cnt == 0);
            r.fin    = (c + 1 == nv);
            if (keep)
                pending_medians.push_back(r);
        end
    endfunction

    // drive at the falling edge, look at tready just before the rising edge
    task automatic send_item(input logic [31:0] v, input logic [4:0] vl, input logic lst,
                             input bit typed, input logic [31:0] med, input logic emp);
        bit rdy;
        median_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tdata  = {3'b000, vl, v};
        s_axis_tlast  = lst;
        s_axis_tvalid = 1'b1;
        do
        begin
            #4;
            rdy = s_axis_tready;
            if (rdy)
            begin
                last_act = cyc;
                predict_medians(v, vl, lst, !typed);
                if (typed)
                begin
                    r.column = '0;
                    r.median = med;
                    r.empty  = emp;
                    r.fin    = 1'b1;
                    pending_medians.push_back(r);
                end
            end
            @(negedge clk);
        end
        while (!rdy);
        s_axis_tvalid = 1'b0;
        items_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return MISSING_MARK;
            1: return END_MARK;
            2, 3: return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_record(input logic [4:0] vl, input int len);
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1)
                send_item(pick_value(), vl, 1'b1, 1'b0, '0, 1'b0);
            else
                send_item(pick_value(), 5'($urandom_range(0, 31)), 1'b0, 1'b0, '0, 1'b0);
        end
        records_sent++;
    endtask

    // a record with no columns leaves the block idle with nothing expected
    task automatic wait_idle();
        while (pending_medians.size() != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
    endtask

    task automatic write_samples(input logic [8:0] n);
        wait_idle();
        cfg_data    = n;
        cfg_we      = 1'b1;
        samples_cfg = n;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic add_row(input logic [31:0] v, input logic [4:0] vl, input logic lst,
                           input bit typed, input logic [31:0] med, input logic emp);
        dir_row_t d;
        d.value = v;
        d.vlen = vl;
        d.last = lst;
        d.typed = typed;
        d.exp_median = med;
        d.exp_empty = emp;
        dir_tab.push_back(d);
    endtask

    // receiver
    initial
    begin
        median_t want;
        bit acc;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_done = 1'b1;
            end
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            #4;
            acc = m_axis_tvalid;
            if (acc)
            begin
                last_act = cyc;
                if (pending_medians.size() == 0)
                begin
                    report_mismatch("unexpected result, column", m_axis_tdata[3:0], '0);
                end
                else
                begin
                    want = pending_medians.pop_front();
                    if (m_axis_tdata[3:0] !== want.column)
                        report_mismatch("column", m_axis_tdata[3:0], want.column);
                    if (m_axis_tdata[35:4] !== want.median)
                        report_mismatch("median", m_axis_tdata[35:4], want.median);
                    if (m_axis_tuser !== want.empty)
                        report_mismatch("empty", m_axis_tuser, want.empty);
                    if (m_axis_tlast !== want.fin)
                        report_mismatch("final", m_axis_tlast, want.fin);
                end
                results_seen++;
            end
        end
    end

    // watchdog on cycles without any accepted item
    initial
    begin
        cyc = 0;
        last_act = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc - last_act > IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int ns;
        int nv;
        int need;
        int len;
        int phase;
        bit ok;
        logic [4:0] vl;
        logic [8:0] sc_plan [8];

        sc_plan = '{9'd3, 9'd0, 9'd511, 9'd2, 9'd5, 9'd256, 9'd4, 9'd6};
        err_count = 0;
        items_sent = 0;
        results_seen = 0;
        records_sent = 0;
        hold_req = 0;
        hold_done = 0;
        quiet = 0;
        wr_pos = '0;
        samples_cfg = 9'd1;
        foreach (store_copy[i])
        begin
            store_copy[i] = '0;
            store_written[i] = 1'b0;
        end
        rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tvalid = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // one sample per record after reset: the median is the value itself, or empty for a mark
        add_row(32'h7fff_ffff, 5'd1, 1'b1, 1'b1, 32'h7fff_ffff, 1'b0);
        add_row(32'h8000_0002, 5'd1, 1'b1, 1'b1, 32'h8000_0002, 1'b0);
        add_row(MISSING_MARK, 5'd1, 1'b1, 1'b1, MISSING_MARK, 1'b1);
        add_row(END_MARK, 5'd1, 1'b1, 1'b1, MISSING_MARK, 1'b1);
        add_row(32'h0000_0000, 5'd1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
        add_row(32'hffff_ffff, 5'd1, 1'b1, 1'b1, 32'hffff_ffff, 1'b0);
        // three columns
        add_row(32'h0000_0005, 5'd0, 1'b0, 1'b0, '0, 1'b0);
        add_row(END_MARK, 5'd31, 1'b0, 1'b0, '0, 1'b0);
        add_row(32'hffff_fffb, 5'd3, 1'b1, 1'b0, '0, 1'b0);
        // no columns: nothing comes out
        add_row(32'h1234_5678, 5'd0, 1'b1, 1'b0, '0, 1'b0);
        // vector length above the column limit is clamped
        for (int i = 0; i < 15; i++)
            add_row($urandom, 5'd0, 1'b0, 1'b0, '0, 1'b0);
        add_row(MISSING_MARK, 5'd17, 1'b1, 1'b0, '0, 1'b0);

        foreach (dir_tab[i])
            send_item(dir_tab[i].value, dir_tab[i].vlen, dir_tab[i].last,
                      dir_tab[i].typed, dir_tab[i].exp_median, dir_tab[i].exp_empty);

        phase = 0;
        while (items_sent < RAND_ITEMS + dir_tab.size())
        begin
            write_samples((phase < 8) ? sc_plan[phase] : 9'($urandom_range(1, 6)));
            if (phase == 3)
                hold_req = 1'b1;
            ns = (samples_cfg > NSAMP) ? NSAMP : samples_cfg;
            for (int r = 0; r < ((ns >= 64) ? 1 : 3) &&
                 items_sent < RAND_ITEMS + dir_tab.size(); r++)
            begin
                if (ns >= 64)
                    vl = 5'd1;
                else
                    case ($urandom_range(0, 9))
                        0: vl = 5'd0;
                        1: vl = 5'($urandom_range(17, 31));
                        default: vl = 5'($urandom_range(1, 16));
                    endcase
                nv = (vl > NCOL) ? NCOL : vl;
                need = ns * nv;
                if (need == 0)
                    len = $urandom_range(1, 6);
                else
                begin
                    len = need;
                    if ($urandom_range(0, 5) == 0)
                        len = need + $urandom_range(1, 4);
                    else if ($urandom_range(0, 5) == 0)
                    begin
                        // short record only over addresses already loaded
                        len = $urandom_range(1, need);
                        ok = 1'b1;
                        for (int a = len; a < need; a++)
                            if (!store_written[a])
                                ok = 1'b0;
                        if (!ok)
                            len = need;
                    end
                end
                send_record(vl, len);
                if (items_sent > RAND_ITEMS - 60)
                    quiet = 1'b1;
            end
            phase++;
        end

        wait_idle();
        repeat (200) @(negedge clk);
        $display("covered %0d items in %0d random records over %0d settings", items_sent,
                 records_sent, phase);
        $display("%0d column medians checked, including a long output stall", results_seen);
        if (err_count == 0 && pending_medians.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
